// File: rtl/dbpid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbpid_pkg: shared types and constants of the deadband pid fan core
// register indexes, reset values, datapath widths and the config struct
// ----------------------------------------------------------------------------
package dbpid_pkg;

    // register file addressing
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_MARGIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD_BAND    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FLOOR    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CEILING  = 3'd6;

    // field widths
    localparam int MARGIN_W = 8;
    localparam int GUARD_W  = 6;
    localparam int GAIN_W   = 16;
    localparam int DUTY_W   = 7;
    localparam int ERR_W    = 8;
    localparam int CHAN_W   = 1;

    // datapath widths
    localparam int BAND_W = 10;  // signed band edges and margin
    localparam int DIFF_W = 10;  // signed first and second differences
    localparam int PROD_W = 27;  // signed gain times difference
    localparam int SUM_W  = 30;  // signed q22.8 sum
    localparam int FRAC_W = 8;   // q22.8 fraction bits
    localparam int INT_W  = SUM_W - FRAC_W;

    // reset values
    localparam logic [MARGIN_W-1:0] RST_TARGET_MARGIN = 8'd20;
    localparam logic [GUARD_W-1:0]  RST_GUARD_BAND    = 6'd2;
    localparam logic [GAIN_W-1:0]   RST_GAIN_PROP     = 16'd256;
    localparam logic [GAIN_W-1:0]   RST_GAIN_INTEG    = 16'd64;
    localparam logic [GAIN_W-1:0]   RST_GAIN_DERIV    = 16'd0;
    localparam logic [DUTY_W-1:0]   RST_DUTY_FLOOR    = 7'd20;
    localparam logic [DUTY_W-1:0]   RST_DUTY_CEILING  = 7'd100;

    typedef struct packed {
        logic [MARGIN_W-1:0] target_margin;
        logic [GUARD_W-1:0]  guard_band;
        logic [GAIN_W-1:0]   gain_prop;
        logic [GAIN_W-1:0]   gain_integ;
        logic [GAIN_W-1:0]   gain_deriv;
        logic [DUTY_W-1:0]   duty_floor;
        logic [DUTY_W-1:0]   duty_ceiling;
    } t_cfg;

endpackage

// File: rtl/dbpid_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbpid_in_if: sample request channel
// valid/ready handshake carrying channel, margin and base duty
// ----------------------------------------------------------------------------
interface dbpid_in_if;
    logic                            valid;
    logic                            ready;
    logic [dbpid_pkg::CHAN_W-1:0]    channel;
    logic [dbpid_pkg::MARGIN_W-1:0]  measured_margin;
    logic [dbpid_pkg::DUTY_W-1:0]    base_duty;

    modport source (output valid, output channel, output measured_margin,
                    output base_duty, input ready);
    modport sink   (input valid, input channel, input measured_margin,
                    input base_duty, output ready);
endinterface

// File: rtl/dbpid_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbpid_out_if: duty result channel
// valid/ready handshake carrying the clamped duty
// ----------------------------------------------------------------------------
interface dbpid_out_if;
    logic                          valid;
    logic                          ready;
    logic [dbpid_pkg::DUTY_W-1:0]  duty_out;

    modport source (output valid, output duty_out, input ready);
    modport sink   (input valid, input duty_out, output ready);
endinterface

// File: rtl/dbpid_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbpid_cfg: configuration register file
// write-only registers, unknown indexes are dropped
// ----------------------------------------------------------------------------
module dbpid_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [dbpid_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dbpid_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output dbpid_pkg::t_cfg                      o_cfg
);

    dbpid_pkg::t_cfg r_cfg;
    dbpid_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dbpid_pkg::CFG_TARGET_MARGIN:
                    n_cfg.target_margin = i_cfg_data[dbpid_pkg::MARGIN_W-1:0];
                dbpid_pkg::CFG_GUARD_BAND:
                    n_cfg.guard_band = i_cfg_data[dbpid_pkg::GUARD_W-1:0];
                dbpid_pkg::CFG_GAIN_PROP:
                    n_cfg.gain_prop = i_cfg_data[dbpid_pkg::GAIN_W-1:0];
                dbpid_pkg::CFG_GAIN_INTEG:
                    n_cfg.gain_integ = i_cfg_data[dbpid_pkg::GAIN_W-1:0];
                dbpid_pkg::CFG_GAIN_DERIV:
                    n_cfg.gain_deriv = i_cfg_data[dbpid_pkg::GAIN_W-1:0];
                dbpid_pkg::CFG_DUTY_FLOOR:
                    n_cfg.duty_floor = i_cfg_data[dbpid_pkg::DUTY_W-1:0];
                dbpid_pkg::CFG_DUTY_CEILING:
                    n_cfg.duty_ceiling = i_cfg_data[dbpid_pkg::DUTY_W-1:0];
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_margin <= dbpid_pkg::RST_TARGET_MARGIN;
            r_cfg.guard_band    <= dbpid_pkg::RST_GUARD_BAND;
            r_cfg.gain_prop     <= dbpid_pkg::RST_GAIN_PROP;
            r_cfg.gain_integ    <= dbpid_pkg::RST_GAIN_INTEG;
            r_cfg.gain_deriv    <= dbpid_pkg::RST_GAIN_DERIV;
            r_cfg.duty_floor    <= dbpid_pkg::RST_DUTY_FLOOR;
            r_cfg.duty_ceiling  <= dbpid_pkg::RST_DUTY_CEILING;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/dbpid_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbpid_calc: deadband error and incremental pid duty
// band error, three parallel gain products, q22.8 sum, truncate and clamp
// ----------------------------------------------------------------------------
module dbpid_calc (
    input  dbpid_pkg::t_cfg                     i_cfg,
    input  logic [dbpid_pkg::MARGIN_W-1:0]      i_margin,
    input  logic [dbpid_pkg::DUTY_W-1:0]        i_base,
    input  logic [dbpid_pkg::ERR_W-1:0]         i_err_last,
    input  logic [dbpid_pkg::ERR_W-1:0]         i_err_prev,
    output logic [dbpid_pkg::ERR_W-1:0]         o_err,
    output logic [dbpid_pkg::DUTY_W-1:0]        o_duty
);

    localparam int BW = dbpid_pkg::BAND_W;
    localparam int DW = dbpid_pkg::DIFF_W;
    localparam int PW = dbpid_pkg::PROD_W;
    localparam int SW = dbpid_pkg::SUM_W;
    localparam int FW = dbpid_pkg::FRAC_W;
    localparam int IW = dbpid_pkg::INT_W;
    localparam int GW = dbpid_pkg::GAIN_W;
    localparam int EW = dbpid_pkg::ERR_W;
    localparam int YW = dbpid_pkg::DUTY_W;

    logic signed [BW-1:0]   band_lo;
    logic signed [BW-1:0]   band_hi;
    logic signed [BW-1:0]   meas;
    logic signed [BW-1:0]   band_dist;
    logic signed [DW-1:0]   diff1;
    logic signed [DW-1:0]   diff2;
    logic signed [PW-1:0]   prod_p;
    logic        [GW+EW-1:0] prod_i;
    logic signed [PW-1:0]   prod_d;
    logic signed [SW-1:0]   sum;
    logic signed [IW-1:0]   quot;
    logic signed [IW-1:0]   floor_s;
    logic signed [IW-1:0]   ceil_s;

    // band edges; the low edge may go negative
    assign band_lo = $signed({2'b00, i_cfg.target_margin})
                   - $signed({4'b0000, i_cfg.guard_band});
    assign band_hi = $signed({2'b00, i_cfg.target_margin})
                   + $signed({4'b0000, i_cfg.guard_band});
    assign meas    = $signed({2'b00, i_margin});

    always_comb begin
        priority if (meas < band_lo) begin
            band_dist = band_lo - meas;
        end else if (meas > band_hi) begin
            band_dist = meas - band_hi;
        end else begin
            band_dist = '0;
        end
    end

    // distance never exceeds 255
    assign o_err = band_dist[EW-1:0];

    assign diff1 = $signed({2'b00, o_err}) - $signed({2'b00, i_err_last});
    assign diff2 = $signed({2'b00, o_err}) - $signed({1'b0, i_err_last, 1'b0})
                 + $signed({2'b00, i_err_prev});

    assign prod_p = $signed({1'b0, i_cfg.gain_prop}) * diff1;
    assign prod_i = i_cfg.gain_integ * o_err;
    assign prod_d = $signed({1'b0, i_cfg.gain_deriv}) * diff2;

    assign sum = $signed({{(SW-YW-FW){1'b0}}, i_base, {FW{1'b0}}})
               + $signed({{(SW-PW){prod_p[PW-1]}}, prod_p})
               + $signed({{(SW-GW-EW){1'b0}}, prod_i})
               + $signed({{(SW-PW){prod_d[PW-1]}}, prod_d});

    // truncate toward zero: round the floor up for negative non-integers
    always_comb begin
        quot = sum[SW-1:FW];
        if (sum[SW-1] && (|sum[FW-1:0])) begin
            quot = quot + IW'(1);
        end
    end

    assign floor_s = $signed({{(IW-YW){1'b0}}, i_cfg.duty_floor});
    assign ceil_s  = $signed({{(IW-YW){1'b0}}, i_cfg.duty_ceiling});

    // floor test first so a crossed floor and ceiling favors the floor
    always_comb begin
        priority if (quot <= floor_s) begin
            o_duty = i_cfg.duty_floor;
        end else if (quot >= ceil_s) begin
            o_duty = i_cfg.duty_ceiling;
        end else begin
            o_duty = quot[YW-1:0];
        end
    end

endmodule

// File: rtl/deadband_incremental_pid_fan_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadband_incremental_pid_fan_core: per-channel deadband incremental pid
// fan duty controller with a write-only configuration port
// ----------------------------------------------------------------------------
// usage
//   i_in carries one sensor request: channel, measured margin, base duty.
//   o_out returns one clamped duty per request, in request order.
//   the user writes registers via i_cfg_we / i_cfg_idx / i_cfg_data only
//   with no request in flight (unchecked); unknown indexes are ignored.
// pipeline and throughput
//   a request sits in the input register while the error, the three gain
//   products and the clamp are formed; the duty lands in the output register
//   when the request advances and is offered from there until it is taken.
//   one request per cycle is sustained while o_out.ready stays high; the
//   error history of a channel is updated as the duty enters the output
//   register, so a back-to-back request for the same channel already sees it.
// reset
//   synchronous on i_rst_n low: registers take their defaults, both error
//   histories of every channel clear to zero, the pipeline empties.
// stall
//   while o_out.ready is low the result holds; one more request can still
//   enter the input register, then i_in.ready drops.
// ----------------------------------------------------------------------------
module deadband_incremental_pid_fan_core #(
    parameter int CHANNELS = 2
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    dbpid_in_if.sink                             i_in,
    dbpid_out_if.source                          o_out,
    input  logic                                 i_cfg_we,
    input  logic [dbpid_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dbpid_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int EW = dbpid_pkg::ERR_W;
    localparam int YW = dbpid_pkg::DUTY_W;
    localparam int CW = dbpid_pkg::CHAN_W;
    localparam int MW = dbpid_pkg::MARGIN_W;

    dbpid_pkg::t_cfg cfg;

    // input stage
    logic          r_in_vld;
    logic [CW-1:0] r_in_ch;
    logic [MW-1:0] r_in_margin;
    logic [YW-1:0] r_in_base;

    // output stage
    logic          r_out_vld;
    logic [YW-1:0] r_out_duty;

    // per-channel error history
    logic [EW-1:0] r_err_last [CHANNELS];
    logic [EW-1:0] r_err_prev [CHANNELS];

    logic          in_acc;
    logic          out_free;
    logic          advance;
    logic [EW-1:0] err_last_sel;
    logic [EW-1:0] err_prev_sel;
    logic [EW-1:0] err_new;
    logic [YW-1:0] duty_new;

    dbpid_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // output register frees when empty or when the result is taken
    assign out_free    = !r_out_vld || o_out.ready;
    assign advance     = r_in_vld && out_free;
    assign i_in.ready  = !r_in_vld || out_free;
    assign in_acc      = i_in.valid && i_in.ready;

    // history select; a channel beyond the table reads zero history
    always_comb begin
        err_last_sel = '0;
        err_prev_sel = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (32'(r_in_ch) == c) begin
                err_last_sel = r_err_last[c];
                err_prev_sel = r_err_prev[c];
            end
        end
    end

    dbpid_calc u_calc (
        .i_cfg      (cfg),
        .i_margin   (r_in_margin),
        .i_base     (r_in_base),
        .i_err_last (err_last_sel),
        .i_err_prev (err_prev_sel),
        .o_err      (err_new),
        .o_duty     (duty_new)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_ch     <= i_in.channel;
            r_in_margin <= i_in.measured_margin;
            r_in_base   <= i_in.base_duty;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_duty <= duty_new;
        end
    end

    // history shifts when the request moves into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_err_last[c] <= '0;
                r_err_prev[c] <= '0;
            end
        end else if (advance) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (32'(r_in_ch) == c) begin
                    r_err_prev[c] <= r_err_last[c];
                    r_err_last[c] <= err_new;
                end
            end
        end
    end

    assign o_out.valid    = r_out_vld;
    assign o_out.duty_out = r_out_duty;

    // a stalled result is never dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_out.ready |=> r_out_vld)
        else $error("result dropped while stalled");

    // an advancing request always produces a result
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_vld && (r_out_duty == $past(duty_new)))
        else $error("advancing request lost");

    // input only blocks when both stages are full and the sink stalls
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_in_vld && r_out_vld && !o_out.ready)
        else $error("input blocked without a stall");

    // a result is the floor, the ceiling or lies between them
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_duty == cfg.duty_floor)
                   || (r_out_duty == cfg.duty_ceiling)
                   || ((r_out_duty > cfg.duty_floor) && (r_out_duty < cfg.duty_ceiling)))
        else $error("duty outside clamp range");

endmodule
